@@ design/ppr_pkg.sv @@
// Shared types and constants for the printer packet receiver.
// Used by the top level, the parser and the checker; depends on nothing.
package ppr_pkg;

    localparam int BUFFER_BYTES = 8192;
    localparam int STRIP_BYTES  = 640;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int FILL_W       = $clog2(BUFFER_BYTES + 1);
    // 640 = 128 * 5: divide by 128 with a shift, then by 5 with a reciprocal
    localparam int STRIP_SHIFT  = 7;
    localparam int QUOT_W       = FILL_W - STRIP_SHIFT;
    localparam int RECIP5       = 205;
    localparam int RECIP5_SHIFT = 10;
    localparam int MAX_STRIPS   = 15;
    localparam int TDATA_W      = 32;

    localparam logic [7:0] SYNC1_BYTE = 8'h88;
    localparam logic [7:0] SYNC2_BYTE = 8'h33;
    localparam logic [7:0] ALIVE_BYTE = 8'h81;
    localparam logic [7:0] IDLE_BYTE  = 8'h00;

    localparam logic [7:0] CMD_INIT   = 8'h01;
    localparam logic [7:0] CMD_PRINT  = 8'h02;
    localparam logic [7:0] CMD_DATA   = 8'h04;
    localparam logic [7:0] CMD_STATUS = 8'h0F;

    typedef enum logic [3:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_CMD,
        PH_COMP,
        PH_LENLO,
        PH_LENHI,
        PH_DATA,
        PH_CHKLO,
        PH_CHKHI,
        PH_ALIVE,
        PH_STATUS
    } phase_t;

    typedef struct packed {
        logic [3:0] strips_ready;
        logic [3:0] feed_lines;
        logic [7:0] palette;
        logic       print_strobe;
        logic       claimed;
        logic [7:0] reply_byte;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } tile_wr_t;

endpackage

@@ design/printer_packet_receiver.sv @@
// Top level of the printer packet receiver: stream ports, output register,
// parser and tile store RAM. Uses ppr_pkg, ppr_parser, ppr_ram.

// One byte in gives one result out, one byte per clock while the output is
// not stalled. Each byte is parsed in the cycle it is accepted and its result
// is registered into the output register on acceptance; the input stays ready
// while that register is empty or being drained, so a stalled result holds
// off the input until it is taken. The tile store is a single-port-write RAM
// that takes at most one payload byte per cycle; it is written only, and its
// contents never reach the result. No clearing pass is needed after reset.
module printer_packet_receiver
    import ppr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] serial_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    // [7:0] reply_byte, [8] claimed, [9] print_strobe, [17:10] palette,
    // [21:18] feed_lines, [25:22] strips_ready, [31:26] zero
    output logic [TDATA_W-1:0] m_tdata
);

    logic     accept;
    result_t  result;
    tile_wr_t tile_wr;
    logic     m_valid_reg, m_valid_next;
    result_t  m_data_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    ppr_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .serial_byte (s_tdata),
        .result      (result),
        .tile_wr     (tile_wr)
    );

    ppr_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_tile_ram (
        .aclk    (aclk),
        .we      (tile_wr.we),
        .wr_addr (tile_wr.addr),
        .wr_data (tile_wr.data),
        .rd_addr (tile_wr.addr),
        .rd_data ()
    );

    assign m_valid_next = accept || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'(m_data_reg);

endmodule

@@ design/ppr_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ppr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/ppr_parser.sv @@
// Packet parser: sync hunt, header, payload and trailer phases, command
// dispatch. Produces one result per byte and the tile store write. Uses ppr_pkg.
module ppr_parser
    import ppr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] serial_byte,
    output result_t    result,
    output tile_wr_t   tile_wr
);

    phase_t            phase_reg, phase_next;
    logic [7:0]        cmd_reg, cmd_next;
    logic              comp_reg, comp_next;
    logic [15:0]       len_reg, len_next;
    logic [15:0]       cnt_reg, cnt_next;
    logic [7:0]        params_reg [4];
    logic [7:0]        params_next [4];
    logic [2:0]        ppos_reg, ppos_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    logic [15:0]              cnt_inc;
    logic [15:0]              len_full;
    logic [QUOT_W-1:0]        quot128;
    logic [QUOT_W+7:0]        quot_prod;
    logic [QUOT_W+7:0]        strips_full;
    logic                     store_room;

    assign cnt_inc    = cnt_reg + 16'd1;
    assign len_full   = {serial_byte, len_reg[7:0]};
    assign store_room = fill_reg < FILL_W'(BUFFER_BYTES);
    assign quot128    = fill_reg[FILL_W-1:STRIP_SHIFT];
    assign quot_prod  = (QUOT_W+8)'(quot128) * (QUOT_W+8)'(RECIP5);
    assign strips_full = quot_prod >> RECIP5_SHIFT;

    always_comb begin
        phase_next  = phase_reg;
        cmd_next    = cmd_reg;
        comp_next   = comp_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        params_next = params_reg;
        ppos_next   = ppos_reg;
        fill_next   = fill_reg;
        result      = '0;
        tile_wr.we   = 1'b0;
        tile_wr.addr = fill_reg[ADDR_W-1:0];
        tile_wr.data = serial_byte;

        unique case (phase_reg)
            PH_SYNC1: begin
                if (serial_byte == SYNC1_BYTE) begin
                    phase_next = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                if (serial_byte == SYNC2_BYTE) begin
                    phase_next = PH_CMD;
                    ppos_next  = '0;
                end else if (serial_byte != SYNC1_BYTE) begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_CMD: begin
                cmd_next   = serial_byte;
                phase_next = PH_COMP;
            end
            PH_COMP: begin
                comp_next  = serial_byte != 8'd0;
                phase_next = PH_LENLO;
            end
            PH_LENLO: begin
                len_next   = {8'd0, serial_byte};
                phase_next = PH_LENHI;
            end
            PH_LENHI: begin
                len_next   = len_full;
                cnt_next   = '0;
                phase_next = (len_full == 16'd0) ? PH_CHKLO : PH_DATA;
            end
            PH_DATA: begin
                if (cmd_reg == CMD_DATA && !comp_reg) begin
                    if (store_room) begin
                        tile_wr.we = 1'b1;
                        fill_next  = fill_reg + FILL_W'(1);
                    end
                end else if (cmd_reg == CMD_PRINT && !ppos_reg[2]) begin
                    params_next[ppos_reg[1:0]] = serial_byte;
                    ppos_next = ppos_reg + 3'd1;
                end
                cnt_next = cnt_inc;
                if (cnt_inc >= len_reg) begin
                    phase_next = PH_CHKLO;
                end
            end
            PH_CHKLO: phase_next = PH_CHKHI;
            PH_CHKHI: phase_next = PH_ALIVE;
            PH_ALIVE: begin
                result.reply_byte = ALIVE_BYTE;
                phase_next = PH_STATUS;
            end
            PH_STATUS: begin
                result.reply_byte = IDLE_BYTE;
                if (cmd_reg == CMD_INIT) begin
                    fill_next = '0;
                end else if (cmd_reg == CMD_PRINT) begin
                    result.print_strobe = 1'b1;
                    result.palette      = params_reg[2];
                    result.feed_lines   = params_reg[1][3:0];
                    result.strips_ready = (strips_full > (QUOT_W+8)'(MAX_STRIPS))
                                        ? 4'(MAX_STRIPS) : strips_full[3:0];
                    fill_next = '0;
                end
                phase_next = PH_SYNC1;
            end
            default: phase_next = PH_SYNC1;
        endcase

        result.claimed = (phase_reg != PH_SYNC1) || (phase_next != PH_SYNC1);
        tile_wr.we     = tile_wr.we && accept;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SYNC1;
            cmd_reg    <= '0;
            comp_reg   <= 1'b0;
            len_reg    <= '0;
            cnt_reg    <= '0;
            params_reg <= '{default: '0};
            ppos_reg   <= '0;
            fill_reg   <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            cmd_reg    <= cmd_next;
            comp_reg   <= comp_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
            params_reg <= params_next;
            ppos_reg   <= ppos_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

@@ design/ppr_checker.sv @@
// Port-level checks for printer_packet_receiver, bound to the top level.
// Uses ppr_pkg.
module ppr_checker
    import ppr_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic [7:0]         s_tdata,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // alive reply only inside a packet, and nothing else but idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] == IDLE_BYTE)
                  || (m_tdata[7:0] == ALIVE_BYTE && m_tdata[8]))
        else $error("bad reply byte");

    // print fields are zero without a strobe; strobe lies inside a packet
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[9] |-> m_tdata[25:10] == '0)
        else $error("print fields without strobe");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |-> m_tdata[8] && m_tdata[7:0] == IDLE_BYTE
            && m_tdata[31:26] == '0)
        else $error("strobe outside status slot");

    // strip count bounded by buffer capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[25:22]) <= 32'(BUFFER_BYTES / STRIP_BYTES))
        else $error("strip count above capacity");

endmodule

bind printer_packet_receiver ppr_checker u_ppr_checker (.*);
